### rtl/gsvm_pkg.sv
// shared types, constants and helper functions of the greedy slot value maximizer
package gsvm_pkg;

  localparam int VAL_W     = 10;
  localparam int HGT_W     = 20;
  localparam int SLOT_W    = 20;
  localparam int SUM_W     = 32;
  localparam int MAX_ITEMS = 4096;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int NVAL      = 1 << VAL_W;
  localparam int GRP_W     = 5;
  localparam int GRP_N     = 1 << GRP_W;
  localparam int BIT_W     = VAL_W - GRP_W;
  localparam int BIT_N     = 1 << BIT_W;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int ADDR_W    = 3;
  localparam logic [ADDR_W-1:0] REG_SLOT_COUNT = 3'd0;

  typedef struct packed {
    logic             last;
    logic [HGT_W-1:0] height;
    logic [VAL_W-1:0] value;
  } item_t;

  function automatic logic [GRP_W-1:0] msb_idx(input logic [GRP_N-1:0] w);
    logic [GRP_W-1:0] r;
    r = '0;
    for (int i = 0; i < GRP_N; i++) begin
      if (w[i]) r = GRP_W'(i);
    end
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

### rtl/gsvm_ram.sv
// generic single-write, single-read memory with registered read data
module gsvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/gsvm_front.sv
// input side: takes words off the stream and queues them for the solver
module gsvm_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // item_value [9:0], item_height [29:10]
  input  logic                   s_tlast,
  output logic                   q_valid,
  output gsvm_pkg::item_t        q_item,
  input  logic                   q_ready
);

  gsvm_pkg::item_t fifo [gsvm_pkg::QDEPTH];
  logic [gsvm_pkg::QPTR_W-1:0] wp;
  logic [gsvm_pkg::QPTR_W-1:0] rp;
  logic [gsvm_pkg::QPTR_W:0]   cnt;
  logic                        push;
  logic                        pop;

  assign s_tready = (cnt != (gsvm_pkg::QPTR_W + 1)'(gsvm_pkg::QDEPTH));
  assign q_valid  = (cnt != '0);
  assign q_item   = fifo[rp];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= '{last: s_tlast,
                    height: s_tdata[gsvm_pkg::VAL_W +: gsvm_pkg::HGT_W],
                    value: s_tdata[gsvm_pkg::VAL_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

### rtl/gsvm_back.sv
// solver: loads the item store, then fills slots greedily from a value-bucket max store
module gsvm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  gsvm_pkg::item_t                   q_item,
  output logic                              q_ready,
  input  logic [gsvm_pkg::SLOT_W-1:0]       slot_count,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata    // total_value [31:0]
);

  localparam logic [3:0] ST_LOAD    = 4'd0;
  localparam logic [3:0] ST_SCAN_RD = 4'd1;
  localparam logic [3:0] ST_SCAN_CK = 4'd2;
  localparam logic [3:0] ST_SCAN_WR = 4'd3;
  localparam logic [3:0] ST_DECIDE  = 4'd4;
  localparam logic [3:0] ST_POP_G   = 4'd5;
  localparam logic [3:0] ST_POP_B   = 4'd6;
  localparam logic [3:0] ST_POP_UPD = 4'd7;
  localparam logic [3:0] ST_FIN     = 4'd8;

  localparam int HW = gsvm_pkg::HGT_W;
  localparam int VW = gsvm_pkg::VAL_W;

  logic [3:0]                   state;
  logic [gsvm_pkg::CNT_W-1:0]   cnt;
  logic [gsvm_pkg::CNT_W-1:0]   idx;
  logic [gsvm_pkg::CNT_W-1:0]   idx_inc;
  logic [HW:0]                  slot;
  logic [HW-1:0]                thr;
  logic [HW-1:0]                cur;
  logic [HW-1:0]                nxt;
  logic                         first;
  logic                         found;
  logic [gsvm_pkg::SUM_W-1:0]   sum;
  logic [VW-1:0]                pv;
  logic [gsvm_pkg::GRP_W-1:0]   pg;
  logic [gsvm_pkg::BIT_N-1:0]   pword;
  logic [gsvm_pkg::BIT_N-1:0]   grp [gsvm_pkg::GRP_N];
  logic [gsvm_pkg::GRP_N-1:0]   summ;
  logic [gsvm_pkg::GRP_W-1:0]   gtop;
  logic [gsvm_pkg::GRP_W-1:0]   gsel;
  logic [gsvm_pkg::BIT_N-1:0]   gword;
  logic                         pbit;
  logic [HW+VW-1:0]             item_q;
  logic [HW-1:0]                ih;
  logic [VW-1:0]                iv;
  logic                         push_ok;
  logic                         cnt_we;
  logic [VW-1:0]                cnt_raddr;
  logic [gsvm_pkg::CNT_W-1:0]   cnt_wdata;
  logic [gsvm_pkg::CNT_W-1:0]   cq;
  logic [HW:0]                  s_ext;
  logic [HW:0]                  nxt_ext;
  logic                         load_last;

  assign q_ready   = (state == ST_LOAD);
  assign load_last = q_ready && q_valid && q_item.last;
  assign ih        = item_q[VW +: HW];
  assign iv        = item_q[VW-1:0];
  assign push_ok   = (first || (ih > cur)) && (ih <= thr);
  assign idx_inc   = idx + 1'b1;
  assign s_ext     = {1'b0, slot_count};
  assign nxt_ext   = {1'b0, nxt};

  always_comb begin
    for (int g = 0; g < gsvm_pkg::GRP_N; g++) summ[g] = |grp[g];
  end

  assign gtop  = gsvm_pkg::msb_idx(summ);
  assign gsel  = (state == ST_POP_G) ? gtop : pv[VW-1 -: gsvm_pkg::GRP_W];
  assign gword = grp[gsel];
  assign pbit  = gword[pv[gsvm_pkg::BIT_W-1:0]];

  assign cnt_raddr = (state == ST_POP_B) ? {pg, gsvm_pkg::msb_idx(pword)} : iv;
  assign cnt_we    = (state == ST_SCAN_WR) || (state == ST_POP_UPD);
  assign cnt_wdata = (state == ST_SCAN_WR) ? (pbit ? cq + 1'b1 : gsvm_pkg::CNT_W'(1))
                                           : cq - 1'b1;

  gsvm_ram #(.WIDTH(HW + VW), .DEPTH(gsvm_pkg::MAX_ITEMS)) u_items (
    .clk   (clk),
    .we    (q_ready && q_valid && !cnt[gsvm_pkg::IDX_W]),
    .waddr (cnt[gsvm_pkg::IDX_W-1:0]),
    .wdata ({q_item.height, q_item.value}),
    .raddr (idx[gsvm_pkg::IDX_W-1:0]),
    .rdata (item_q)
  );

  gsvm_ram #(.WIDTH(gsvm_pkg::CNT_W), .DEPTH(gsvm_pkg::NVAL)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (pv),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cq)
  );

  always_ff @(posedge clk) begin
    if (rst || load_last) begin
      for (int g = 0; g < gsvm_pkg::GRP_N; g++) grp[g] <= '0;
    end else if (state == ST_SCAN_WR) begin
      grp[pv[VW-1 -: gsvm_pkg::GRP_W]][pv[gsvm_pkg::BIT_W-1:0]] <= 1'b1;
    end else if (state == ST_POP_UPD && cq == gsvm_pkg::CNT_W'(1)) begin
      grp[pv[VW-1 -: gsvm_pkg::GRP_W]][pv[gsvm_pkg::BIT_W-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      cnt      <= '0;
      idx      <= '0;
      slot     <= '0;
      thr      <= '0;
      cur      <= '0;
      nxt      <= '0;
      first    <= 1'b0;
      found    <= 1'b0;
      sum      <= '0;
      pv       <= '0;
      pg       <= '0;
      pword    <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (q_valid) begin
            if (!cnt[gsvm_pkg::IDX_W]) cnt <= cnt + 1'b1;
            if (q_item.last) begin
              slot  <= (HW + 1)'(1);
              thr   <= HW'(1);
              cur   <= '0;
              first <= 1'b1;
              found <= 1'b0;
              sum   <= '0;
              idx   <= '0;
              state <= (slot_count == '0) ? ST_FIN : ST_SCAN_RD;
            end
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CK;
        end
        ST_SCAN_CK, ST_SCAN_WR: begin
          if (state == ST_SCAN_CK && ih > thr && (!found || ih < nxt)) begin
            found <= 1'b1;
            nxt   <= ih;
          end
          if (state == ST_SCAN_CK && push_ok) begin
            pv    <= iv;
            state <= ST_SCAN_WR;
          end else begin
            idx <= idx_inc;
            if (idx_inc == cnt) begin
              cur   <= thr;
              first <= 1'b0;
              state <= ST_DECIDE;
            end else begin
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_DECIDE: begin
          if (slot > s_ext) begin
            state <= ST_FIN;
          end else if (summ == '0) begin
            if (!found || nxt_ext > s_ext) begin
              state <= ST_FIN;
            end else begin
              slot  <= nxt_ext;
              thr   <= nxt;
              idx   <= '0;
              found <= 1'b0;
              state <= ST_SCAN_RD;
            end
          end else if (found && slot == nxt_ext) begin
            thr   <= nxt;
            idx   <= '0;
            found <= 1'b0;
            state <= ST_SCAN_RD;
          end else begin
            state <= ST_POP_G;
          end
        end
        ST_POP_G: begin
          pg    <= gtop;
          pword <= gword;
          state <= ST_POP_B;
        end
        ST_POP_B: begin
          pv    <= {pg, gsvm_pkg::msb_idx(pword)};
          state <= ST_POP_UPD;
        end
        ST_POP_UPD: begin
          sum   <= gsvm_pkg::sat_add(sum, pv);
          slot  <= slot + 1'b1;
          state <= ST_DECIDE;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= sum;
            cnt      <= '0;
            state    <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  ast_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= gsvm_pkg::CNT_W'(gsvm_pkg::MAX_ITEMS))
    else $error("item count beyond store depth");

  ast_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_POP_G |-> summ != '0)
    else $error("pop from empty value store");

  ast_pop_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_POP_UPD |-> cq != '0)
    else $error("popped bucket has zero count");

  ast_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN_RD |-> idx < cnt)
    else $error("scan index past item count");

  ast_slot_pop: assert property (@(posedge clk) disable iff (rst)
    state == ST_POP_UPD |=> $past(slot) + 1'b1 == slot)
    else $error("slot did not advance after pop");

endmodule

### rtl/greedy_slot_value_maximizer.sv
// top level of the greedy slot value maximizer: stream ports, config register, front and back
// Words are taken one per cycle, while the queue has room, into a four-word queue; the back
// end writes them into a 4096-entry item memory one per cycle while it is loading (items
// beyond 4096 are dropped, a dropped last word still starts the solve). After the last word
// the solver scans the whole item memory once for the first slot and once more for each
// later height that is reached, reading each item and pushing those that fit into the
// value-bucket store, and then takes a decision; each filled slot then passes through the
// decide, group pop, bucket pop and count update states, and the result sits in an output
// register until taken. The queue keeps accepting words during the solve until it is full.
module greedy_slot_value_maximizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // item_value [9:0], item_height [29:10]
  input  logic                          s_tlast,   // last_item
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // total_value [31:0]
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gsvm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [gsvm_pkg::SLOT_W-1:0] slot_count;
  logic                        q_valid;
  logic                        q_ready;
  gsvm_pkg::item_t             q_item;

  assign pready = 1'b1;
  assign prdata = (paddr == gsvm_pkg::REG_SLOT_COUNT) ? 32'(slot_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr == gsvm_pkg::REG_SLOT_COUNT) begin
      slot_count <= pwdata[gsvm_pkg::SLOT_W-1:0];
    end
  end

  gsvm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready)
  );

  gsvm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready),
    .slot_count (slot_count),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
